>>> design/lprl_pkg.sv
package lprl_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int ADDR_W = 32;
  localparam int LEN_W = 6;
  localparam int PORT_W = 8;
  localparam int VLAN_W = 12;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_CONNECTED = 2'd1;
  localparam logic [1:0] FUNC_STATIC = 2'd2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_NOIF = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    logic              connected;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

>>> design/longest_prefix_route_lookup.sv
// Transactions are taken one at a time: in_ready is high only while the controller is idle.
// The scan reads the route table RAM through its single read port, one entry per cycle.
// A result waiting for out_ready holds the final commit step, and no new transaction is
// taken until that commit is done.
// Reset (rst_n, synchronous, active low) clears all entry valid bits, the controller
// and the result valid flag; the table contents themselves are not cleared.
module longest_prefix_route_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_func,
  input  logic [lprl_pkg::ADDR_W-1:0]      in_address,
  input  logic [lprl_pkg::LEN_W-1:0]       in_prefix_len,
  input  logic [lprl_pkg::ADDR_W-1:0]      in_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0]      in_out_port,
  input  logic [lprl_pkg::VLAN_W-1:0]      in_out_vlan,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [lprl_pkg::ADDR_W-1:0]      out_route_next_hop,
  output logic [lprl_pkg::PORT_W-1:0]      out_route_port,
  output logic [lprl_pkg::VLAN_W-1:0]      out_route_vlan,
  output logic                             out_route_connected
);

  import lprl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lprl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  lprl_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_func            (in_func),
    .in_address         (in_address),
    .in_prefix_len      (in_prefix_len),
    .in_next_hop        (in_next_hop),
    .in_out_port        (in_out_port),
    .in_out_vlan        (in_out_vlan),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_route_next_hop (out_route_next_hop),
    .out_route_port     (out_route_port),
    .out_route_vlan     (out_route_vlan),
    .out_route_connected(out_route_connected)
  );

endmodule

>>> design/lprl_ram.sv
module lprl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/lprl_ctrl.sv
module lprl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lprl_pkg::dp_status_t   status,
  output lprl_pkg::ctrl_cmd_t    cmd
);

  import lprl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_addr = cnt_r;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SCAN && cnt_r == '0)
    else $error("accepted transaction did not start a scan at entry zero");

  a_scan_reads_all: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> $past(cmd.rd_en) && $past(cnt_r) == LAST_IDX)
    else $error("scan ended before the last entry was read");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.out_free && state_r == S_DONE)
    else $error("commit issued while the result register was occupied");

endmodule

>>> design/lprl_datapath.sv
module lprl_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lprl_pkg::ctrl_cmd_t              cmd,
  output lprl_pkg::dp_status_t             status,
  input  logic [1:0]                       in_func,
  input  logic [lprl_pkg::ADDR_W-1:0]      in_address,
  input  logic [lprl_pkg::LEN_W-1:0]       in_prefix_len,
  input  logic [lprl_pkg::ADDR_W-1:0]      in_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0]      in_out_port,
  input  logic [lprl_pkg::VLAN_W-1:0]      in_out_vlan,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [lprl_pkg::ADDR_W-1:0]      out_route_next_hop,
  output logic [lprl_pkg::PORT_W-1:0]      out_route_port,
  output logic [lprl_pkg::VLAN_W-1:0]      out_route_vlan,
  output logic                             out_route_connected
);

  import lprl_pkg::*;

  // Latched transaction.
  logic [1:0]        func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] nh_r;
  logic [PORT_W-1:0] port_r;
  logic [VLAN_W-1:0] vlan_r;

  logic [ROUTE_ENTRIES-1:0] valid_r;

  logic             eval_r;
  logic [IDX_W-1:0] eval_idx_r;

  logic              best_found_r;
  logic [LEN_W-1:0]  best_len_r;
  logic              best_conn_r;
  logic [ADDR_W-1:0] best_nh_r;
  logic [PORT_W-1:0] best_port_r;
  logic [VLAN_W-1:0] best_vlan_r;

  logic             conn_found_r;
  logic [IDX_W-1:0] conn_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_nh_r;
  logic [PORT_W-1:0] out_port_r;
  logic [VLAN_W-1:0] out_vlan_r;
  logic              out_conn_r;

  logic [ENTRY_W-1:0] rd_data;
  entry_t             e;
  logic               e_valid;
  logic               hit;
  logic               better;
  logic               conn_hit;
  logic               free_hit;

  logic               we;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_entry;
  logic [1:0]         res_status;
  logic [ADDR_W-1:0]  res_nh;
  logic [PORT_W-1:0]  res_port;
  logic [VLAN_W-1:0]  res_vlan;
  logic               res_conn;
  logic [LEN_W-1:0]   in_len_sat;

  lprl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ROUTE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_idx),
    .wr_data(wr_entry),
    .rd_en  (cmd.rd_en),
    .rd_addr(cmd.rd_addr),
    .rd_data(rd_data)
  );

  assign in_len_sat = (in_prefix_len > MAX_LEN) ? MAX_LEN : in_prefix_len;

  assign e        = entry_t'(rd_data);
  assign e_valid  = eval_r && valid_r[eval_idx_r];
  assign hit      = e_valid && ((addr_r & len_mask(e.len)) == e.prefix);
  assign better   = hit && (!best_found_r || (e.len > best_len_r) ||
                    ((e.len == best_len_r) && e.connected && !best_conn_r));
  assign conn_hit = e_valid && e.connected && (e.port == port_r) && (e.vlan == vlan_r);
  assign free_hit = eval_r && !valid_r[eval_idx_r];

  always_comb begin
    we         = 1'b0;
    wr_idx     = free_idx_r;
    res_status = STAT_OK;
    res_nh     = '0;
    res_port   = '0;
    res_vlan   = '0;
    res_conn   = 1'b0;
    wr_entry.prefix    = addr_r & len_mask(len_r);
    wr_entry.len       = len_r;
    wr_entry.gateway   = nh_r;
    wr_entry.port      = port_r;
    wr_entry.vlan      = vlan_r;
    wr_entry.connected = 1'b0;
    case (func_r)
      FUNC_LOOKUP: begin
        if (best_found_r) begin
          res_nh   = best_conn_r ? addr_r : best_nh_r;
          res_port = best_port_r;
          res_vlan = best_vlan_r;
          res_conn = best_conn_r;
        end else begin
          res_status = STAT_MISS;
        end
      end
      FUNC_CONNECTED: begin
        wr_entry.gateway   = '0;
        wr_entry.connected = 1'b1;
        if (conn_found_r) begin
          wr_idx = conn_idx_r;
          we     = cmd.commit;
        end else if (free_found_r) begin
          we = cmd.commit;
        end else begin
          res_status = STAT_FULL;
        end
      end
      FUNC_STATIC: begin
        if (!conn_found_r) begin
          res_status = STAT_NOIF;
        end else if (free_found_r) begin
          we = cmd.commit;
        end else begin
          res_status = STAT_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      addr_r <= in_address;
      len_r  <= in_len_sat;
      nh_r   <= in_next_hop;
      port_r <= in_out_port;
      vlan_r <= in_out_vlan;
    end
    eval_idx_r <= cmd.rd_addr;
    if (better) begin
      best_len_r  <= e.len;
      best_conn_r <= e.connected;
      best_nh_r   <= e.gateway;
      best_port_r <= e.port;
      best_vlan_r <= e.vlan;
    end
    if (conn_hit && !conn_found_r) begin
      conn_idx_r <= eval_idx_r;
    end
    if (free_hit && !free_found_r) begin
      free_idx_r <= eval_idx_r;
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_nh_r     <= res_nh;
      out_port_r   <= res_port;
      out_vlan_r   <= res_vlan;
      out_conn_r   <= res_conn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      eval_r       <= 1'b0;
      best_found_r <= 1'b0;
      conn_found_r <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      eval_r <= cmd.rd_en;
      if (cmd.load) begin
        best_found_r <= 1'b0;
        conn_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (better) begin
          best_found_r <= 1'b1;
        end
        if (conn_hit) begin
          conn_found_r <= 1'b1;
        end
        if (free_hit) begin
          free_found_r <= 1'b1;
        end
      end
      if (we) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free     = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_route_next_hop  = out_nh_r;
  assign out_route_port      = out_port_r;
  assign out_route_vlan      = out_vlan_r;
  assign out_route_connected = out_conn_r;

  a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed transaction did not reach the result register");

  a_static_needs_interface: assert property (@(posedge clk) disable iff (!rst_n)
    we && func_r == FUNC_STATIC |-> conn_found_r && !valid_r[wr_idx])
    else $error("static route stored without an interface or over a live entry");

  a_write_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> cmd.commit && !cmd.rd_en && !eval_r)
    else $error("table written during a scan");

endmodule

>>> dv/route_lookup_checker.sv
`timescale 1ns / 1ps
module route_lookup_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [lprl_pkg::ADDR_W-1:0] in_address,
  input  logic [lprl_pkg::LEN_W-1:0]  in_prefix_len,
  input  logic [lprl_pkg::ADDR_W-1:0] in_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0] in_out_port,
  input  logic [lprl_pkg::VLAN_W-1:0] in_out_vlan,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  out_status,
  input  logic [lprl_pkg::ADDR_W-1:0] out_route_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0] out_route_port,
  input  logic [lprl_pkg::VLAN_W-1:0] out_route_vlan,
  input  logic                        out_route_connected,
  output int                          mismatch_count,
  output int                          outstanding
);
  import lprl_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    logic              connected;
  } route_result_t;

  logic          tbl_valid [ROUTE_ENTRIES];
  entry_t        tbl_entry [ROUTE_ENTRIES];
  route_result_t expected_routes [$];
  int            mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  function automatic int connected_slot(input logic [PORT_W-1:0] port,
                                        input logic [VLAN_W-1:0] vlan);
    int i;
    for (i = 0; i < ROUTE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_entry[i].connected && tbl_entry[i].port == port &&
          tbl_entry[i].vlan == vlan) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int free_slot();
    int i;
    for (i = 0; i < ROUTE_ENTRIES; i++) begin
      if (!tbl_valid[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic install_entry(input int slot, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] nh,
                               input logic [PORT_W-1:0] port, input logic [VLAN_W-1:0] vlan,
                               input logic connected);
    tbl_valid[slot] = 1'b1;
    tbl_entry[slot].prefix = addr & prefix_mask(len);
    tbl_entry[slot].len = len;
    tbl_entry[slot].gateway = nh;
    tbl_entry[slot].port = port;
    tbl_entry[slot].vlan = vlan;
    tbl_entry[slot].connected = connected;
  endtask

  task automatic predict_route(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] len_in, input logic [ADDR_W-1:0] nh,
                               input logic [PORT_W-1:0] port, input logic [VLAN_W-1:0] vlan,
                               output route_result_t res);
    logic [LEN_W-1:0] len;
    int               best;
    int               slot;
    int               i;
    len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
    res = '0;
    res.status = STAT_OK;
    case (func)
      FUNC_LOOKUP: begin
        best = -1;
        for (i = 0; i < ROUTE_ENTRIES; i++) begin
          if (tbl_valid[i] &&
              ((addr & prefix_mask(tbl_entry[i].len)) == tbl_entry[i].prefix)) begin
            if (best < 0) begin
              best = i;
            end else if (tbl_entry[i].len > tbl_entry[best].len) begin
              best = i;
            end else if (tbl_entry[i].len == tbl_entry[best].len &&
                         tbl_entry[i].connected && !tbl_entry[best].connected) begin
              best = i;
            end
          end
        end
        if (best < 0) begin
          res.status = STAT_MISS;
        end else begin
          res.gateway = tbl_entry[best].connected ? addr : tbl_entry[best].gateway;
          res.port = tbl_entry[best].port;
          res.vlan = tbl_entry[best].vlan;
          res.connected = tbl_entry[best].connected;
        end
      end
      FUNC_CONNECTED: begin
        slot = connected_slot(port, vlan);
        if (slot < 0) begin
          slot = free_slot();
        end
        if (slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          install_entry(slot, addr, len, '0, port, vlan, 1'b1);
        end
      end
      FUNC_STATIC: begin
        if (connected_slot(port, vlan) < 0) begin
          res.status = STAT_NOIF;
        end else begin
          slot = free_slot();
          if (slot < 0) begin
            res.status = STAT_FULL;
          end else begin
            install_entry(slot, addr, len, nh, port, vlan, 1'b0);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string field_name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field_name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    route_result_t want;
    route_result_t got;
    int            i;
    if (!rst_n) begin
      for (i = 0; i < ROUTE_ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
      end
      expected_routes.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.gateway = out_route_next_hop;
        got.port = out_route_port;
        got.vlan = out_route_vlan;
        got.connected = out_route_connected;
        if (expected_routes.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual status %0d",
                   $time, got.status);
          mismatches++;
        end else begin
          want = expected_routes.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("route_next_hop", want.gateway, got.gateway);
          check_field("route_port", 32'(want.port), 32'(got.port));
          check_field("route_vlan", 32'(want.vlan), 32'(got.vlan));
          check_field("route_connected", 32'(want.connected), 32'(got.connected));
        end
      end
      if (in_valid && in_ready) begin
        predict_route(in_func, in_address, in_prefix_len, in_next_hop, in_out_port,
                      in_out_vlan, want);
        expected_routes.insert(expected_routes.size(), want);
      end
    end
    outstanding <= expected_routes.size();
  end

endmodule

>>> dv/longest_prefix_route_lookup_tb.sv
`timescale 1ns / 1ps
module longest_prefix_route_lookup_tb;
  import lprl_pkg::*;

  localparam logic [1:0] FUNC_RESERVED = 2'd3;
  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 5;
  localparam int MAX_GAP = 6;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 430;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = FUNC_LOOKUP;
  logic [ADDR_W-1:0] in_address = '0;
  logic [LEN_W-1:0]  in_prefix_len = '0;
  logic [ADDR_W-1:0] in_next_hop = '0;
  logic [PORT_W-1:0] in_out_port = '0;
  logic [VLAN_W-1:0] in_out_vlan = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_route_next_hop;
  logic [PORT_W-1:0] out_route_port;
  logic [VLAN_W-1:0] out_route_vlan;
  logic              out_route_connected;

  int   mismatch_count;
  int   outstanding;
  int   idle_cycles = 0;
  logic calm = 1'b0;
  logic hold_off_req = 1'b0;

  logic [PORT_W-1:0] ifc_port [$];
  logic [VLAN_W-1:0] ifc_vlan [$];
  logic [ADDR_W-1:0] pfx_addr [$];
  logic [LEN_W-1:0]  pfx_len [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  longest_prefix_route_lookup uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_address          (in_address),
    .in_prefix_len       (in_prefix_len),
    .in_next_hop         (in_next_hop),
    .in_out_port         (in_out_port),
    .in_out_vlan         (in_out_vlan),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_route_next_hop  (out_route_next_hop),
    .out_route_port      (out_route_port),
    .out_route_vlan      (out_route_vlan),
    .out_route_connected (out_route_connected)
  );

  route_lookup_checker route_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_address          (in_address),
    .in_prefix_len       (in_prefix_len),
    .in_next_hop         (in_next_hop),
    .in_out_port         (in_out_port),
    .in_out_vlan         (in_out_vlan),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_route_next_hop  (out_route_next_hop),
    .out_route_port      (out_route_port),
    .out_route_vlan      (out_route_vlan),
    .out_route_connected (out_route_connected),
    .mismatch_count      (mismatch_count),
    .outstanding         (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_route_item(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                                 input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] nh,
                                 input logic [PORT_W-1:0] port,
                                 input logic [VLAN_W-1:0] vlan);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_address <= addr;
    in_prefix_len <= len;
    in_next_hop <= nh;
    in_out_port <= port;
    in_out_vlan <= vlan;
    do @(posedge clk); while (!in_ready);
    if (func == FUNC_CONNECTED) begin
      ifc_port.insert(ifc_port.size(), port);
      ifc_vlan.insert(ifc_vlan.size(), vlan);
    end
    if (func == FUNC_CONNECTED || func == FUNC_STATIC) begin
      pfx_addr.insert(pfx_addr.size(), addr);
      pfx_len.insert(pfx_len.size(), (len > MAX_LEN) ? MAX_LEN : len);
    end
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_random_item(output bit counted);
    int                sel;
    int                k;
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] nh;
    logic [ADDR_W-1:0] mask;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    sel = $urandom_range(0, 99);
    addr = $urandom;
    nh = $urandom;
    port = PORT_W'($urandom);
    vlan = VLAN_W'($urandom);
    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(33, 63))
                                      : LEN_W'($urandom_range(0, 32));
    if (sel < 50) begin
      func = FUNC_LOOKUP;
      if (pfx_addr.size() > 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, pfx_addr.size() - 1);
        mask = ~(32'hFFFF_FFFF >> pfx_len[k]);
        addr = (pfx_addr[k] & mask) | (addr & ~mask);
      end
    end else if (sel < 68) begin
      func = FUNC_CONNECTED;
      if (ifc_port.size() > 0 && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, ifc_port.size() - 1);
        port = ifc_port[k];
        vlan = ifc_vlan[k];
      end else if ($urandom_range(0, 1) == 1) begin
        port = PORT_W'($urandom_range(0, 3));
        vlan = VLAN_W'($urandom_range(0, 2));
      end
    end else if (sel < 95) begin
      func = FUNC_STATIC;
      if (ifc_port.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, ifc_port.size() - 1);
        port = ifc_port[k];
        vlan = ifc_vlan[k];
      end
    end else begin
      func = FUNC_RESERVED;
    end
    send_route_item(func, addr, len, nh, port, vlan);
    counted = (func != FUNC_RESERVED);
  endtask

  initial begin : result_sink
    int stall;
    bit hold_off_done;
    hold_off_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int counted_items;
    bit counted;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_route_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'h0000_0000, 6'd0, 32'hFFFF_FFFF, 8'hFF, 12'hFFF);
    send_route_item(FUNC_CONNECTED, 32'h0A12_3456, 6'd8, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_CONNECTED, 32'hC0A8_01FF, 6'd24, 32'hFFFF_FFFF, 8'hFF, 12'hFFF);
    send_route_item(FUNC_LOOKUP, 32'h0A01_0203, 6'd63, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_CONNECTED, 32'h0A01_FFFF, 6'd16, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_LOOKUP, 32'h0A02_0304, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'hDEAD_BEEF, 6'd0, 32'hFFFF_FFFF, 8'hFF, 12'hFFF);
    send_route_item(FUNC_LOOKUP, 32'h0A02_0304, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'hFFFF_FFFF, 6'd63, 32'h0102_0304, 8'h00, 12'h000);
    send_route_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'h0A01_0000, 6'd16, 32'h0A00_00FE, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'hAC10_0000, 6'd12, 32'hC0A8_0101, 8'hFF, 12'hFFF);
    send_route_item(FUNC_CONNECTED, 32'hAC1F_FFFF, 6'd12, 32'h0, 8'h05, 12'h007);
    send_route_item(FUNC_LOOKUP, 32'hAC14_0101, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'h1400_0000, 6'd8, 32'h1111_1111, 8'h00, 12'h000);
    send_route_item(FUNC_STATIC, 32'h14FF_FFFF, 6'd8, 32'h2222_2222, 8'h05, 12'h007);
    send_route_item(FUNC_LOOKUP, 32'h14AB_CDEF, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_LOOKUP, 32'h0A01_FFFF, 6'd0, 32'h0, 8'h00, 12'h000);
    send_route_item(FUNC_RESERVED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 12'hFFF);
    send_route_item(FUNC_STATIC, 32'h3300_0000, 6'd8, 32'h3333_3333, 8'h05, 12'h008);
    wait_until_drained();

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (counted_items == 150) begin
        calm <= 1'b1;
        hold_off_req <= 1'b1;
      end
      if (counted_items == 170) begin
        calm <= 1'b0;
      end
      if (counted_items == 250) begin
        wait_until_drained();
      end
      if (counted_items == 300) begin
        calm <= 1'b1;
      end
      if (counted_items == 360) begin
        calm <= 1'b0;
      end
      send_random_item(counted);
      if (counted) begin
        counted_items++;
      end
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
